[src/fatlb_pkg.sv]
// ----------------------------------------------------------------------------
// fatlb_pkg
// Shared types and codes for the fully associative translation buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package fatlb_pkg;

    // Operation codes carried in s_tuser.
    typedef enum logic [2:0] {
        OP_LOOKUP     = 3'd0,
        OP_INSERT     = 3'd1,
        OP_INVALIDATE = 3'd2,
        OP_FLUSH_ALL  = 3'd3,
        OP_FLUSH_ASID = 3'd4,
        OP_MISS       = 3'd5
    } op_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_APPLY
    } state_t;

    // Payload of one buffer slot.
    typedef struct packed {
        logic [19:0] virt_page;
        logic [19:0] phys_page;
        logic [11:0] flags;
        logic [15:0] asid;
        logic        glb;
        logic [1:0]  kind;
        logic [1:0]  pg_size;
    } entry_t;

    // Command broadcast to every cell in the row.
    typedef struct packed {
        logic        wr;
        logic        inval;
        logic        flush_all;
        logic        flush_glb;
        logic        flush_asid;
        logic [15:0] asid;
        logic        touch;
    } cell_cmd_t;

    localparam logic [11:0] MISS_FLAGS   = 12'h003;
    localparam logic [7:0]  ADDR_CUR_ASID = 8'h00;

endpackage

`default_nettype wire

[src/fatlb_cell.sv]
// ----------------------------------------------------------------------------
// fatlb_cell
// One buffer slot: valid bit, payload, recency rank and the links of the
// first-match and first-free chains that run along the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module fatlb_cell
    import fatlb_pkg::*;
#(
    parameter int RW    = 5,
    parameter int INDEX = 0,
    parameter int MAXR  = 31
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [19:0]   cmp_page,
    input  wire cell_cmd_t     cmd,
    input  wire logic          sel,
    input  wire entry_t        wdata,
    input  wire logic [RW-1:0] touch_rank,
    input  wire logic          match_in,
    input  wire logic          free_in,
    output logic               match_out,
    output logic               free_out,
    output logic               match_first,
    output logic               free_first,
    output logic               lru,
    output logic [RW-1:0]      rank,
    output entry_t             entry
);

    logic          valid_reg;
    logic          valid_next;
    logic [RW-1:0] rank_reg;
    logic [RW-1:0] rank_next;
    entry_t        entry_reg;
    logic          match;

    // Compare and chain links toward the higher slots.
    assign match       = valid_reg && (entry_reg.virt_page == cmp_page);
    assign match_first = match && !match_in;
    assign match_out   = match || match_in;
    assign free_first  = !valid_reg && !free_in;
    assign free_out    = !valid_reg || free_in;
    assign lru         = (rank_reg == '0);
    assign rank        = rank_reg;
    assign entry       = entry_reg;

    // Valid bit update.
    always_comb begin
        valid_next = valid_reg;
        if (cmd.wr && sel) begin
            valid_next = 1'b1;
        end
        if (cmd.inval && sel) begin
            valid_next = 1'b0;
        end
        if (cmd.flush_all && (cmd.flush_glb || !entry_reg.glb)) begin
            valid_next = 1'b0;
        end
        if (cmd.flush_asid && valid_reg && (entry_reg.asid == cmd.asid)) begin
            valid_next = 1'b0;
        end
    end

    // Recency: the touched slot moves to the top, those above it step down.
    always_comb begin
        rank_next = rank_reg;
        if (cmd.touch) begin
            if (sel) begin
                rank_next = RW'(MAXR);
            end else if (rank_reg > touch_rank) begin
                rank_next = rank_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= RW'(INDEX);
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    // Payload holds no reset.
    always_ff @(posedge aclk) begin
        if (cmd.wr && sel) begin
            entry_reg <= wdata;
        end
    end

endmodule

`default_nettype wire

[src/fully_assoc_tlb_lru.sv]
// ----------------------------------------------------------------------------
// fully_assoc_tlb_lru
// Fully associative translation buffer with true LRU replacement.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_ stream (s_tuser holds the operation, s_tdata
// the page and entry fields); every item yields exactly one transfer on the
// m_ stream (m_tuser holds the hit flag, m_tdata the entry and counters).
// Each item passes through a compare pass, where the row of cells
// matches the page and resolves the first match, first free slot and LRU
// slot along its chains, and then an update pass that writes the chosen
// cell and the recency ranks. A new item is taken in the update pass of
// the one before it, when the output register is free. The output
// register holds a finished result while the receiver stalls; the update
// pass then waits until it is free.
// The user must write the ASID register for miss handling (APB port, byte
// address 0) while the block is idle; the block itself does not enforce it.
// Reset (aresetn low, synchronous) clears all valid bits, the counters and
// the output, and sets each slot's rank to its index. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module fully_assoc_tlb_lru
    import fatlb_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // APB configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [19:0] virt_page, [39:20] phys_page, [51:40] page_flags, [67:52] asid,
    // [68] global_page, [70:69] entry_kind, [72:71] size_code,
    // [73] clear_global, [79:74] zero
    input  wire logic [79:0]  s_tdata,
    // [2:0] operation
    input  wire logic [2:0]   s_tuser,
    // Result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [19:0] out_phys_page, [31:20] out_flags, [47:32] out_asid,
    // [48] out_global, [50:49] out_kind, [52:51] out_size_code,
    // [84:53] hit_count, [116:85] miss_count, [148:117] invalidation_count,
    // [180:149] flush_count, [183:181] zero
    output logic [183:0]      m_tdata,
    // [0] hit
    output logic [0:0]        m_tuser
);

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [15:0]         cur_asid_reg;
    logic [2:0]          op_reg;
    logic [79:0]         item_reg;
    logic [ENTRIES-1:0]  tgt_reg;
    logic                hit_reg;
    entry_t              hit_entry_reg;
    logic [RW-1:0]       tgt_rank_reg;
    logic [31:0]         hits_reg, misses_reg, invals_reg, flushes_reg;
    logic [31:0]         hits_next, misses_next, invals_next, flushes_next;
    logic                m_valid_reg;
    logic [183:0]        m_data_reg;
    logic                m_hit_reg;

    // Item fields
    logic [19:0] it_vp, it_pp;
    logic [11:0] it_flags;
    logic [15:0] it_asid;
    logic        it_glb, it_fg;
    logic [1:0]  it_kind, it_ps;

    assign it_vp    = item_reg[19:0];
    assign it_pp    = item_reg[39:20];
    assign it_flags = item_reg[51:40];
    assign it_asid  = item_reg[67:52];
    assign it_glb   = item_reg[68];
    assign it_kind  = item_reg[70:69];
    assign it_ps    = item_reg[72:71];
    assign it_fg    = item_reg[73];

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CUR_ASID[2:0]) ? {16'd0, cur_asid_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_asid_reg <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == ADDR_CUR_ASID[2:0])) begin
            cur_asid_reg <= pwdata[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake and sequencer
    // ------------------------------------------------------------------
    logic out_free;
    logic accept;
    logic apply;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_APPLY) && out_free);
    assign accept   = s_tvalid && s_tready;
    assign apply    = (state_reg == ST_APPLY) && out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (out_free) state_next = accept ? ST_EVAL : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_tuser;
            item_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Row of cells
    // ------------------------------------------------------------------
    cell_cmd_t           cmd;
    entry_t              wdata;
    logic [ENTRIES:0]    match_chain, free_chain;
    logic [ENTRIES-1:0]  match_first, free_first, lru_vec;
    logic [RW-1:0]       ranks [ENTRIES];
    entry_t              entries [ENTRIES];

    assign match_chain[0] = 1'b0;
    assign free_chain[0]  = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        fatlb_cell #(
            .RW    (RW),
            .INDEX (i),
            .MAXR  (ENTRIES - 1)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmp_page    (it_vp),
            .cmd         (cmd),
            .sel         (tgt_reg[i]),
            .wdata       (wdata),
            .touch_rank  (tgt_rank_reg),
            .match_in    (match_chain[i]),
            .free_in     (free_chain[i]),
            .match_out   (match_chain[i+1]),
            .free_out    (free_chain[i+1]),
            .match_first (match_first[i]),
            .free_first  (free_first[i]),
            .lru         (lru_vec[i]),
            .rank        (ranks[i]),
            .entry       (entries[i])
        );
    end

    // ------------------------------------------------------------------
    // Compare pass: pick the target slot and read the matching entry
    // ------------------------------------------------------------------
    logic [ENTRIES-1:0] tgt_sel;
    entry_t             match_entry;
    logic [RW-1:0]      tgt_rank;

    always_comb begin
        if (match_chain[ENTRIES]) begin
            tgt_sel = match_first;
        end else if (free_chain[ENTRIES]) begin
            tgt_sel = free_first;
        end else begin
            tgt_sel = lru_vec;
        end
    end

    always_comb begin
        match_entry = '0;
        tgt_rank    = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match_entry = match_entry | (match_first[i] ? entries[i] : '0);
            tgt_rank    = tgt_rank | (tgt_sel[i] ? ranks[i] : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EVAL) begin
            tgt_reg       <= tgt_sel;
            hit_reg       <= match_chain[ENTRIES];
            hit_entry_reg <= match_entry;
            tgt_rank_reg  <= tgt_rank;
        end
    end

    // ------------------------------------------------------------------
    // Update pass: cell commands, counters and the result
    // ------------------------------------------------------------------
    logic   res_hit;
    entry_t res_entry;

    always_comb begin
        cmd          = '0;
        cmd.asid     = it_asid;
        cmd.flush_glb = it_fg;
        wdata        = '{virt_page: it_vp, phys_page: it_pp, flags: it_flags,
                         asid: it_asid, glb: it_glb, kind: it_kind,
                         pg_size: it_ps};
        res_hit      = 1'b0;
        res_entry    = '0;
        hits_next    = hits_reg;
        misses_next  = misses_reg;
        invals_next  = invals_reg;
        flushes_next = flushes_reg;
        case (op_reg)
            OP_LOOKUP: begin
                if (hit_reg) begin
                    cmd.touch = apply;
                    res_hit   = 1'b1;
                    res_entry = hit_entry_reg;
                    hits_next = hits_reg + 32'd1;
                end else begin
                    misses_next = misses_reg + 32'd1;
                end
            end
            OP_INSERT: begin
                cmd.wr    = apply;
                cmd.touch = apply;
            end
            OP_INVALIDATE: begin
                cmd.inval   = apply && hit_reg;
                res_hit     = hit_reg;
                invals_next = invals_reg + 32'd1;
            end
            OP_FLUSH_ALL: begin
                cmd.flush_all = apply;
                flushes_next  = flushes_reg + 32'd1;
            end
            OP_FLUSH_ASID: begin
                cmd.flush_asid = apply;
                flushes_next   = flushes_reg + 32'd1;
            end
            OP_MISS: begin
                cmd.touch = apply;
                if (hit_reg) begin
                    res_hit     = 1'b1;
                    res_entry   = hit_entry_reg;
                    hits_next   = hits_reg + 32'd1;
                    misses_next = misses_reg + 32'd1;
                end else begin
                    cmd.wr      = apply;
                    wdata       = '{virt_page: it_vp, phys_page: it_vp,
                                    flags: MISS_FLAGS, asid: cur_asid_reg,
                                    glb: 1'b0, kind: it_kind, pg_size: 2'd0};
                    misses_next = misses_reg + 32'd2;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hits_reg    <= '0;
            misses_reg  <= '0;
            invals_reg  <= '0;
            flushes_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (apply) begin
                hits_reg    <= hits_next;
                misses_reg  <= misses_next;
                invals_reg  <= invals_next;
                flushes_reg <= flushes_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (apply) begin
            m_hit_reg  <= res_hit;
            m_data_reg <= {3'd0, flushes_next, invals_next, misses_next, hits_next,
                           res_entry.pg_size, res_entry.kind, res_entry.glb,
                           res_entry.asid, res_entry.flags, res_entry.phys_page};
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_hit_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_lru: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(lru_vec))
        else $error("recency ranks do not hold exactly one LRU slot");

    a_tgt_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY) |-> $onehot(tgt_reg))
        else $error("update pass target is not a single slot");

    a_out_from_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_APPLY))
        else $error("result appeared without an update pass");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result was overwritten");

endmodule

`default_nettype wire

[tb/fully_assoc_tlb_lru_tb.sv]
// ----------------------------------------------------------------------------
// fully_assoc_tlb_lru_tb
// Self-checking bench for the fully associative LRU translation buffer.
// A queue of operations feeds a stream driver with random gaps. A predictor
// keeps its own copy of the slots, ranks and counters and computes the
// expected result of each accepted transfer. A monitor with random stalls
// compares each result, field by field, with the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fully_assoc_tlb_lru_tb
    import fatlb_pkg::*;
;

    localparam int NSLOT = 32;

    // Input operation as it sits in the pending queue.
    typedef struct packed {
        op_t         op;
        logic [19:0] vp;
        logic [19:0] pp;
        logic [11:0] fl;
        logic [15:0] asid;
        logic        glb;
        logic [1:0]  kind;
        logic [1:0]  psz;
        logic        fglb;
    } tlb_op_t;

    // Expected translation result.
    typedef struct packed {
        logic        hit;
        logic [19:0] pp;
        logic [11:0] fl;
        logic [15:0] asid;
        logic        glb;
        logic [1:0]  kind;
        logic [1:0]  psz;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] invals;
        logic [31:0] flushes;
    } xlat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [79:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [183:0] m_tdata;
    logic [0:0] m_tuser;

    fully_assoc_tlb_lru u_top (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #2 aclk = ~aclk;

    // Predictor state.
    logic        mv_valid [NSLOT];
    entry_t      mv_ent   [NSLOT];
    logic [4:0]  mv_rank  [NSLOT];
    logic [31:0] cnt_hit, cnt_miss, cnt_inval, cnt_flush;
    logic [15:0] cur_asid;

    tlb_op_t pending_ops[$];
    xlat_t   expected_xlats[$];
    int errors = 0;
    int results_seen = 0;
    bit quiet_tail = 0;
    bit stall_long = 0;
    int ops_sent = 0;

    // Pages mostly from a small pool so that hits and evictions are frequent.
    logic [19:0] page_pool [48];

    function automatic int find_slot(logic [19:0] vp);
        for (int i = 0; i < NSLOT; i++)
            if (mv_valid[i] && mv_ent[i].virt_page == vp) return i;
        return -1;
    endfunction

    function automatic void make_mru(int s);
        logic [4:0] r;
        r = mv_rank[s];
        for (int i = 0; i < NSLOT; i++)
            if (mv_rank[i] > r) mv_rank[i] = mv_rank[i] - 5'd1;
        mv_rank[s] = 5'(NSLOT - 1);
    endfunction

    function automatic void store_entry(entry_t e);
        int s;
        s = find_slot(e.virt_page);
        for (int i = 0; i < NSLOT && s < 0; i++)
            if (!mv_valid[i]) s = i;
        if (s < 0)
            for (int i = 0; i < NSLOT; i++)
                if (mv_rank[i] == 0) s = i;
        mv_valid[s] = 1'b1;
        mv_ent[s] = e;
        make_mru(s);
    endfunction

    function automatic bit probe(logic [19:0] vp, ref xlat_t x);
        int s;
        s = find_slot(vp);
        if (s < 0) begin
            cnt_miss++;
            return 0;
        end
        cnt_hit++;
        make_mru(s);
        x.pp = mv_ent[s].phys_page;
        x.fl = mv_ent[s].flags;
        x.asid = mv_ent[s].asid;
        x.glb = mv_ent[s].glb;
        x.kind = mv_ent[s].kind;
        x.psz = mv_ent[s].pg_size;
        return 1;
    endfunction

    function automatic xlat_t translate(tlb_op_t t);
        xlat_t x;
        entry_t e;
        int s;
        x = '0;
        case (t.op)
            OP_LOOKUP: x.hit = probe(t.vp, x);
            OP_INSERT: begin
                e = '{t.vp, t.pp, t.fl, t.asid, t.glb, t.kind, t.psz};
                store_entry(e);
            end
            OP_INVALIDATE: begin
                s = find_slot(t.vp);
                if (s >= 0) begin
                    mv_valid[s] = 1'b0;
                    x.hit = 1'b1;
                end
                cnt_inval++;
            end
            OP_FLUSH_ALL: begin
                for (int i = 0; i < NSLOT; i++)
                    if (t.fglb || !mv_ent[i].glb) mv_valid[i] = 1'b0;
                cnt_flush++;
            end
            OP_FLUSH_ASID: begin
                for (int i = 0; i < NSLOT; i++)
                    if (mv_valid[i] && mv_ent[i].asid == t.asid) mv_valid[i] = 1'b0;
                cnt_flush++;
            end
            OP_MISS: begin
                cnt_miss++;
                if (probe(t.vp, x)) x.hit = 1'b1;
                else begin
                    e = '{t.vp, t.vp, MISS_FLAGS, cur_asid, 1'b0, t.kind, 2'd0};
                    store_entry(e);
                end
            end
            default: ;
        endcase
        x.hits = cnt_hit;
        x.misses = cnt_miss;
        x.invals = cnt_inval;
        x.flushes = cnt_flush;
        return x;
    endfunction

    function automatic tlb_op_t rand_op();
        tlb_op_t t;
        int k;
        t.vp = ($urandom_range(0, 3) == 0) ? 20'($urandom) : page_pool[$urandom_range(0, 47)];
        t.pp = 20'($urandom);
        t.fl = 12'($urandom);
        t.asid = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        t.glb = 1'($urandom);
        t.kind = 2'($urandom);
        t.psz = 2'($urandom);
        t.fglb = 1'($urandom);
        k = $urandom_range(0, 99);
        if (k < 30) t.op = OP_LOOKUP;
        else if (k < 58) t.op = OP_INSERT;
        else if (k < 68) t.op = OP_INVALIDATE;
        else if (k < 71) t.op = OP_FLUSH_ALL;
        else if (k < 75) t.op = OP_FLUSH_ASID;
        else t.op = OP_MISS;
        return t;
    endfunction

    function automatic tlb_op_t mk(op_t op, logic [19:0] vp, logic [19:0] pp,
                                   logic [11:0] fl, logic [15:0] asid, logic glb,
                                   logic [1:0] kind, logic [1:0] psz, logic fglb);
        tlb_op_t t;
        t = '{op, vp, pp, fl, asid, glb, kind, psz, fglb};
        return t;
    endfunction

    // Stream driver with random gaps.
    int gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_xlats.push_back(translate(pending_ops.pop_front()));
                ops_sent++;
            end
            if (gap > 0) begin
                gap <= gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0 && !(s_tvalid && !s_tready) &&
                         !quiet_tail && $urandom_range(0, 19) == 0) begin
                gap <= $urandom_range(0, 8);
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= {6'd0, pending_ops[0].fglb, pending_ops[0].psz,
                            pending_ops[0].kind, pending_ops[0].glb,
                            pending_ops[0].asid, pending_ops[0].fl,
                            pending_ops[0].pp, pending_ops[0].vp};
                s_tuser <= pending_ops[0].op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor with random stalls and one long hold-off.
    int stall = 0;
    always @(posedge aclk) begin
        xlat_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got = {m_tuser[0], m_tdata[19:0], m_tdata[31:20], m_tdata[47:32],
                       m_tdata[48], m_tdata[50:49], m_tdata[52:51], m_tdata[84:53],
                       m_tdata[116:85], m_tdata[148:117], m_tdata[180:149]};
                if (expected_xlats.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, got);
                    errors++;
                end else begin
                    want = expected_xlats.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch hit exp %0d act %0d pp exp %h act %h",
                                 $time, want.hit, got.hit, want.pp, got.pp);
                        $display("    fl %h/%h asid %h/%h glb %0d/%0d kind %0d/%0d psz %0d/%0d",
                                 want.fl, got.fl, want.asid, got.asid, want.glb, got.glb,
                                 want.kind, got.kind, want.psz, got.psz);
                        $display("    counters exp %0d %0d %0d %0d act %0d %0d %0d %0d",
                                 want.hits, want.misses, want.invals, want.flushes,
                                 got.hits, got.misses, got.invals, got.flushes);
                    end
                end
            end
            if (stall_long) m_tready <= 1'b0;
            else if (stall > 0) begin
                stall <= stall - 1;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
                stall <= $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else m_tready <= 1'b1;
        end
    end

    task automatic apb_write(logic [15:0] v);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_CUR_ASID[2:0]; pwdata <= {16'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cur_asid = v;
    endtask

    task automatic drain();
        while (pending_ops.size() > 0 || expected_xlats.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            mv_valid[i] = 0; mv_ent[i] = '0; mv_rank[i] = 5'(i);
        end
        cnt_hit = 0; cnt_miss = 0; cnt_inval = 0; cnt_flush = 0; cur_asid = 0;
        for (int i = 0; i < 48; i++) page_pool[i] = 20'($urandom);
        page_pool[0] = 20'h00000;
        page_pool[1] = 20'hFFFFF;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, every operation, miss handling both ways.
        pending_ops.push_back(mk(OP_LOOKUP, 20'h0, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_INSERT, 20'hFFFFF, 20'hFFFFF, 12'hFFF, 16'hFFFF,
                                 1, 3, 3, 1));
        pending_ops.push_back(mk(OP_INSERT, 20'h0, 20'h0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_LOOKUP, 20'hFFFFF, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_MISS, 20'h12345, 0, 0, 0, 0, 2, 0, 0));
        pending_ops.push_back(mk(OP_MISS, 20'h12345, 0, 0, 0, 0, 1, 0, 0));
        pending_ops.push_back(mk(OP_INSERT, 20'hFFFFF, 20'h5A5A5, 12'h5A5, 16'h1234,
                                 0, 1, 2, 0));
        pending_ops.push_back(mk(OP_INVALIDATE, 20'h0, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_INVALIDATE, 20'h0, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_FLUSH_ASID, 0, 0, 0, 16'h1234, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_INSERT, 20'h00777, 20'h1, 12'h1, 16'h0, 1, 0, 0, 0));
        pending_ops.push_back(mk(OP_FLUSH_ALL, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_LOOKUP, 20'h00777, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_FLUSH_ALL, 0, 0, 0, 0, 0, 0, 0, 1));
        // Fill past capacity so the least recently used slot is evicted.
        for (int i = 0; i < 34; i++)
            pending_ops.push_back(mk(OP_INSERT, 20'(i + 100), 20'($urandom), 12'($urandom),
                                     16'($urandom), 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_LOOKUP, 20'd100, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_LOOKUP, 20'd133, 0, 0, 0, 0, 0, 0, 0));
        drain();
        apb_write(16'hFFFF);

        // Random phases with several ASID settings; hold-off in the first.
        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < 350; i++) pending_ops.push_back(rand_op());
            if (ph == 0) begin
                stall_long = 1;
                repeat (200) @(posedge aclk);
                stall_long = 0;
            end
            if (ph == 3) begin
                while (pending_ops.size() > 60) @(posedge aclk);
                quiet_tail = 1;
            end
            drain();
            apb_write(ph == 0 ? 16'h0000 : 16'($urandom));
        end

        $display("Covered %0d items and %0d results across six operations,", ops_sent,
                 results_seen);
        $display("with evictions, global and ASID flushes and four ASID settings.");
        if (errors == 0) $display("** fully_assoc_tlb_lru: PASSED **");
        else $display("** fully_assoc_tlb_lru: FAILED **");
        $finish;
    end

    initial begin
        #2000000;
        $display("** fully_assoc_tlb_lru: FAILED **");
        $finish;
    end
endmodule
